@@ sv/particle_plane_collision_response_macros.svh @@
// assertion macros shared by the collision response rtl
`ifndef PARTICLE_PLANE_COLLISION_RESPONSE_MACROS_SVH
`define PARTICLE_PLANE_COLLISION_RESPONSE_MACROS_SVH

// same-cycle implication
`define PPC_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("ppc assertion failed");

// next-cycle implication
`define PPC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("ppc assertion failed");

`endif

@@ sv/ppc_pkg.sv @@
// types, constants and helper functions of the collision response block
package ppc_pkg;

	localparam int SQW = 31;
	localparam int DW  = 36;
	localparam int QW  = 16;

	typedef enum logic [2:0] {
		CFG_PLANE_X  = 3'd0,
		CFG_PLANE_Y  = 3'd1,
		CFG_NORMAL_X = 3'd2,
		CFG_NORMAL_Y = 3'd3,
		CFG_RULE     = 3'd4
	} cfg_idx_t;

	localparam logic [14:0] PUSH_FLOOR = 15'd17203;
	localparam logic [14:0] PUSH_WALL  = 15'd16384;
	localparam logic [2:0]  KN_FLOOR   = 3'd1;
	localparam logic [2:0]  KN_WALL    = 3'd6;
	localparam logic [4:0]  KD_FLOOR   = 5'd4;
	localparam logic [4:0]  KD_WALL    = 5'd25;
	localparam logic [31:0] RECIP5     = 32'hCCCCCCCD;
	localparam logic [17:0] WALL_HALF  = 18'd163840;
	localparam logic [16:0] SLOW_MAX   = 17'd41943;
	localparam logic [16:0] A_ONE      = 17'h10000;

	typedef struct packed {
		logic signed [23:0] pnx;
		logic signed [23:0] pny;
		logic signed [23:0] vx;
		logic signed [23:0] vy;
		logic signed [29:0] vnx;
		logic signed [29:0] vny;
		logic signed [30:0] vtx;
		logic signed [30:0] vty;
		logic               pen;
		logic               bnc;
		logic               flr;
	} side_t;

	typedef struct packed {
		logic  kill;
		side_t side;
	} div_pay_t;

	// round half away from zero, shift by 28
	function automatic logic signed [31:0] rnd28(input logic signed [59:0] v);
		logic [59:0] mag;
		logic [59:0] m;
		begin
			mag = v[59] ? $unsigned(-v) : $unsigned(v);
			m = (mag + 60'd134217728) >> 28;
			rnd28 = v[59] ? -$signed(m[31:0]) : $signed(m[31:0]);
		end
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
		begin
			if (v > 34'sd8388607)
				sat24 = 24'sh7FFFFF;
			else if (v < -34'sd8388608)
				sat24 = -24'sh800000;
			else
				sat24 = v[23:0];
		end
	endfunction

endpackage

@@ sv/ppc_sqrt.sv @@
// pipelined two-lane integer square root, one root bit per stage
module ppc_sqrt #(
	parameter int W  = 31,
	parameter int PW = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [2*W-1:0] rad0,
	input  logic [2*W-1:0] rad1,
	input  logic [PW-1:0]  in_pay,
	output logic           out_valid,
	output logic [W-1:0]   root0,
	output logic [W-1:0]   root1,
	output logic [PW-1:0]  out_pay
);

	logic           vld_s  [1:W];
	logic [PW-1:0]  pay_s  [1:W];
	logic [2*W-1:0] rad_s  [1:W][0:1];
	logic [W+1:0]   rem_s  [1:W][0:1];
	logic [W-1:0]   root_s [1:W][0:1];

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic          vld_i;
		logic [PW-1:0] pay_i;
		if (k == 0) begin : g_src
			assign vld_i = in_valid;
			assign pay_i = in_pay;
		end else begin : g_src
			assign vld_i = vld_s[k];
			assign pay_i = pay_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else
				vld_s[k+1] <= vld_i;
		end

		always_ff @(posedge clk) begin
			pay_s[k+1] <= pay_i;
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [2*W-1:0] rad_i;
			logic [W+1:0]   rem_i;
			logic [W-1:0]   root_i;
			logic [W+1:0]   cur;
			logic [W+1:0]   trial;
			if (k == 0) begin : g_src
				assign rad_i  = (l == 0) ? rad0 : rad1;
				assign rem_i  = '0;
				assign root_i = '0;
			end else begin : g_src
				assign rad_i  = rad_s[k][l];
				assign rem_i  = rem_s[k][l];
				assign root_i = root_s[k][l];
			end

			// bring down the next radicand bit pair and try the next root bit
			always_comb begin
				cur   = {rem_i[W-1:0], rad_i[2*(W-1-k)+1 -: 2]};
				trial = {root_i, 2'b01};
			end

			always_ff @(posedge clk) begin
				rad_s[k+1][l] <= rad_i;
				if (cur >= trial) begin
					rem_s[k+1][l]  <= cur - trial;
					root_s[k+1][l] <= {root_i[W-2:0], 1'b1};
				end else begin
					rem_s[k+1][l]  <= cur;
					root_s[k+1][l] <= {root_i[W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[W];
	assign out_pay   = pay_s[W];
	assign root0     = root_s[W][0];
	assign root1     = root_s[W][1];

endmodule

@@ sv/ppc_div.sv @@
// pipelined restoring divider for a proper fraction, one quotient bit per stage
module ppc_div #(
	parameter int W  = 36,
	parameter int QW = 16,
	parameter int PW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [W-1:0]  num,
	input  logic [W-1:0]  den,
	input  logic [PW-1:0] in_pay,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic [PW-1:0] out_pay
);

	logic          vld_s [1:QW];
	logic [PW-1:0] pay_s [1:QW];
	logic [W-1:0]  rem_s [1:QW];
	logic [W-1:0]  den_s [1:QW];
	logic [QW-1:0] quo_s [1:QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic          vld_i;
		logic [PW-1:0] pay_i;
		logic [W-1:0]  rem_i;
		logic [W-1:0]  den_i;
		logic [QW-1:0] quo_i;
		logic [W:0]    sh;
		logic [W:0]    dif;
		if (k == 0) begin : g_src
			assign vld_i = in_valid;
			assign pay_i = in_pay;
			assign rem_i = num;
			assign den_i = den;
			assign quo_i = '0;
		end else begin : g_src
			assign vld_i = vld_s[k];
			assign pay_i = pay_s[k];
			assign rem_i = rem_s[k];
			assign den_i = den_s[k];
			assign quo_i = quo_s[k];
		end

		always_comb begin
			sh  = {rem_i, 1'b0};
			dif = sh - {1'b0, den_i};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else
				vld_s[k+1] <= vld_i;
		end

		always_ff @(posedge clk) begin
			pay_s[k+1] <= pay_i;
			den_s[k+1] <= den_i;
			if (sh >= {1'b0, den_i}) begin
				rem_s[k+1] <= dif[W-1:0];
				quo_s[k+1] <= {quo_i[QW-2:0], 1'b1};
			end else begin
				rem_s[k+1] <= sh[W-1:0];
				quo_s[k+1] <= {quo_i[QW-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign out_pay   = pay_s[QW];
	assign quo       = quo_s[QW];

endmodule

@@ sv/particle_plane_collision_response.sv @@
// particle versus plane collision response, top level pipeline
//
//   channel   handshake                 payload
//   input     start / busy              pos_x pos_y vel_x vel_y
//   result    done (one cycle strobe)   new_pos_x new_pos_y new_vel_x new_vel_y
//                                       penetrated bounced
//   config    cfg_valid / cfg_ready     cfg_index cfg_data
//
// one particle per cycle
// the pipeline runs through the 31-stage square root and the 16-stage divider
// busy and cfg_ready are constant, so every start and cfg beat is taken
// arst_n clears the valid chain and the plane registers (normal defaults to +y)
// the result side cannot stall, so the pipeline never holds
module particle_plane_collision_response (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] vel_x,
	input  logic signed [23:0] vel_y,
	output logic               done,
	output logic signed [23:0] new_pos_x,
	output logic signed [23:0] new_pos_y,
	output logic signed [23:0] new_vel_x,
	output logic signed [23:0] new_vel_y,
	output logic               penetrated,
	output logic               bounced,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	`include "particle_plane_collision_response_macros.svh"

	localparam int LAT = 8 + ppc_pkg::SQW + 1 + ppc_pkg::QW + 5;
	localparam int SPW = $bits(ppc_pkg::side_t);
	localparam int DPW = $bits(ppc_pkg::div_pay_t);

	logic accept;
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// configuration
	logic signed [23:0] plane_x_q, plane_y_q;
	logic signed [15:0] normal_x_q, normal_y_q;
	logic               rule_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_x_q  <= '0;
			plane_y_q  <= '0;
			normal_x_q <= '0;
			normal_y_q <= 16'sd16384;
			rule_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ppc_pkg::CFG_PLANE_X:  plane_x_q  <= cfg_data;
				ppc_pkg::CFG_PLANE_Y:  plane_y_q  <= cfg_data;
				ppc_pkg::CFG_NORMAL_X: normal_x_q <= cfg_data[15:0];
				ppc_pkg::CFG_NORMAL_Y: normal_y_q <= cfg_data[15:0];
				ppc_pkg::CFG_RULE:     rule_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// valid chain of the front stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <=
				{accept, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7};
		end
	end

	// s1: offsets from the plane point
	logic signed [23:0] px_s1, py_s1, vx_s1, vy_s1;
	logic signed [24:0] dx_s1, dy_s1;
	logic               flr_s1;
	always_ff @(posedge clk) begin
		px_s1  <= pos_x;
		py_s1  <= pos_y;
		vx_s1  <= vel_x;
		vy_s1  <= vel_y;
		dx_s1  <= 25'(pos_x) - 25'(plane_x_q);
		dy_s1  <= 25'(pos_y) - 25'(plane_y_q);
		flr_s1 <= (rule_q == 1'b0);
	end

	// s2: dot product terms
	logic signed [23:0] px_s2, py_s2, vx_s2, vy_s2;
	logic signed [40:0] pdx_s2, pdy_s2;
	logic signed [39:0] pvx_s2, pvy_s2;
	logic               flr_s2;
	always_ff @(posedge clk) begin
		px_s2  <= px_s1;
		py_s2  <= py_s1;
		vx_s2  <= vx_s1;
		vy_s2  <= vy_s1;
		pdx_s2 <= 41'(dx_s1) * 41'(normal_x_q);
		pdy_s2 <= 41'(dy_s1) * 41'(normal_y_q);
		pvx_s2 <= 40'(vx_s1) * 40'(normal_x_q);
		pvy_s2 <= 40'(vy_s1) * 40'(normal_y_q);
		flr_s2 <= flr_s1;
	end

	// s3: phi and v.n
	logic signed [23:0] px_s3, py_s3, vx_s3, vy_s3;
	logic signed [41:0] phi_s3;
	logic signed [40:0] vdn_s3;
	logic               flr_s3;
	always_ff @(posedge clk) begin
		px_s3  <= px_s2;
		py_s3  <= py_s2;
		vx_s3  <= vx_s2;
		vy_s3  <= vy_s2;
		phi_s3 <= 42'(pdx_s2) + 42'(pdy_s2);
		vdn_s3 <= 41'(pvx_s2) + 41'(pvy_s2);
		flr_s3 <= flr_s2;
	end

	// s4: push distance product and normal velocity products
	logic [41:0]        phimag;
	logic [14:0]        push;
	logic signed [23:0] px_s4, py_s4, vx_s4, vy_s4;
	logic [56:0]        dmul_s4;
	logic signed [56:0] vnpx_s4, vnpy_s4;
	logic               pen_s4, bnc_s4, flr_s4;
	always_comb begin
		phimag = phi_s3[41] ? $unsigned(-phi_s3) : $unsigned(phi_s3);
		push   = flr_s3 ? ppc_pkg::PUSH_FLOOR : ppc_pkg::PUSH_WALL;
	end
	always_ff @(posedge clk) begin
		px_s4   <= px_s3;
		py_s4   <= py_s3;
		vx_s4   <= vx_s3;
		vy_s4   <= vy_s3;
		dmul_s4 <= 57'(phimag) * 57'(push);
		vnpx_s4 <= 57'(vdn_s3) * 57'(normal_x_q);
		vnpy_s4 <= 57'(vdn_s3) * 57'(normal_y_q);
		pen_s4  <= phi_s3[41];
		bnc_s4  <= phi_s3[41] && vdn_s3[40];
		flr_s4  <= flr_s3;
	end

	// s5: rounded push distance and normal velocity
	logic [56:0]        dsum;
	logic signed [23:0] px_s5, py_s5, vx_s5, vy_s5;
	logic [42:0]        d_s5;
	logic signed [29:0] vnx_s5, vny_s5;
	logic               pen_s5, bnc_s5, flr_s5;
	always_comb begin
		dsum = dmul_s4 + 57'd8192;
	end
	always_ff @(posedge clk) begin
		px_s5  <= px_s4;
		py_s5  <= py_s4;
		vx_s5  <= vx_s4;
		vy_s5  <= vy_s4;
		d_s5   <= dsum[56:14];
		vnx_s5 <= 30'(ppc_pkg::rnd28(60'(vnpx_s4)));
		vny_s5 <= 30'(ppc_pkg::rnd28(60'(vnpy_s4)));
		pen_s5 <= pen_s4;
		bnc_s5 <= bnc_s4;
		flr_s5 <= flr_s4;
	end

	// s6: push vector products and tangent velocity
	logic signed [43:0] dsg;
	logic signed [23:0] px_s6, py_s6, vx_s6, vy_s6;
	logic signed [59:0] dnx_s6, dny_s6;
	logic signed [29:0] vnx_s6, vny_s6;
	logic signed [30:0] vtx_s6, vty_s6;
	logic               pen_s6, bnc_s6, flr_s6;
	always_comb begin
		dsg = $signed({1'b0, d_s5});
	end
	always_ff @(posedge clk) begin
		px_s6  <= px_s5;
		py_s6  <= py_s5;
		vx_s6  <= vx_s5;
		vy_s6  <= vy_s5;
		dnx_s6 <= 60'(dsg) * 60'(normal_x_q);
		dny_s6 <= 60'(dsg) * 60'(normal_y_q);
		vnx_s6 <= vnx_s5;
		vny_s6 <= vny_s5;
		vtx_s6 <= 31'(vx_s5) - 31'(vnx_s5);
		vty_s6 <= 31'(vy_s5) - 31'(vny_s5);
		pen_s6 <= pen_s5;
		bnc_s6 <= bnc_s5;
		flr_s6 <= flr_s5;
	end

	// s7: corrected position and squared components
	logic signed [59:0] sqnx, sqny;
	logic signed [61:0] sqtx, sqty;
	logic signed [23:0] pnx_s7, pny_s7, vx_s7, vy_s7;
	logic [59:0]        sqnx_s7, sqny_s7;
	logic [61:0]        sqtx_s7, sqty_s7;
	logic signed [29:0] vnx_s7, vny_s7;
	logic signed [30:0] vtx_s7, vty_s7;
	logic               pen_s7, bnc_s7, flr_s7;
	always_comb begin
		sqnx = 60'(vnx_s6) * 60'(vnx_s6);
		sqny = 60'(vny_s6) * 60'(vny_s6);
		sqtx = 62'(vtx_s6) * 62'(vtx_s6);
		sqty = 62'(vty_s6) * 62'(vty_s6);
	end
	always_ff @(posedge clk) begin
		pnx_s7  <= pen_s6 ?
			ppc_pkg::sat24(34'(px_s6) + 34'(ppc_pkg::rnd28(dnx_s6))) : px_s6;
		pny_s7  <= pen_s6 ?
			ppc_pkg::sat24(34'(py_s6) + 34'(ppc_pkg::rnd28(dny_s6))) : py_s6;
		vx_s7   <= vx_s6;
		vy_s7   <= vy_s6;
		sqnx_s7 <= $unsigned(sqnx);
		sqny_s7 <= $unsigned(sqny);
		sqtx_s7 <= $unsigned(sqtx);
		sqty_s7 <= $unsigned(sqty);
		vnx_s7  <= vnx_s6;
		vny_s7  <= vny_s6;
		vtx_s7  <= vtx_s6;
		vty_s7  <= vty_s6;
		pen_s7  <= pen_s6;
		bnc_s7  <= bnc_s6;
		flr_s7  <= flr_s6;
	end

	// s8: squared lengths
	logic [61:0]    rn_s8, rt_s8;
	ppc_pkg::side_t side_s8;
	always_ff @(posedge clk) begin
		rn_s8        <= 62'(sqnx_s7) + 62'(sqny_s7);
		rt_s8        <= sqtx_s7 + sqty_s7;
		side_s8.pnx  <= pnx_s7;
		side_s8.pny  <= pny_s7;
		side_s8.vx   <= vx_s7;
		side_s8.vy   <= vy_s7;
		side_s8.vnx  <= vnx_s7;
		side_s8.vny  <= vny_s7;
		side_s8.vtx  <= vtx_s7;
		side_s8.vty  <= vty_s7;
		side_s8.pen  <= pen_s7;
		side_s8.bnc  <= bnc_s7;
		side_s8.flr  <= flr_s7;
	end

	logic                     sq_valid;
	logic [ppc_pkg::SQW-1:0]  ln, lt;
	logic [SPW-1:0]           sq_pay;
	ppc_pkg::side_t           sq_side;

	ppc_sqrt #(
		.W  (ppc_pkg::SQW),
		.PW (SPW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s8),
		.rad0      (rn_s8),
		.rad1      (rt_s8),
		.in_pay    (side_s8),
		.out_valid (sq_valid),
		.root0     (ln),
		.root1     (lt),
		.out_pay   (sq_pay)
	);
	assign sq_side = ppc_pkg::side_t'(sq_pay);

	// s9: scaled lengths; a is zero when the ratio reaches one or lt is zero
	logic [ppc_pkg::DW-1:0] knln, kdlt;
	logic                   v_s9;
	logic [ppc_pkg::DW-1:0] num_s9, den_s9;
	ppc_pkg::div_pay_t      dpay_s9;
	always_comb begin
		knln = 36'(ln) * 36'(sq_side.flr ? ppc_pkg::KN_FLOOR : ppc_pkg::KN_WALL);
		kdlt = 36'(lt) * 36'(sq_side.flr ? ppc_pkg::KD_FLOOR : ppc_pkg::KD_WALL);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s9 <= 1'b0;
		else
			v_s9 <= sq_valid;
	end
	always_ff @(posedge clk) begin
		num_s9       <= knln;
		den_s9       <= kdlt;
		dpay_s9.kill <= (lt == '0) || (knln >= kdlt);
		dpay_s9.side <= sq_side;
	end

	logic                   dv_valid;
	logic [ppc_pkg::QW-1:0] quo;
	logic [DPW-1:0]         dv_pay;
	ppc_pkg::div_pay_t      dv_out;

	ppc_div #(
		.W  (ppc_pkg::DW),
		.QW (ppc_pkg::QW),
		.PW (DPW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s9),
		.num       (num_s9),
		.den       (den_s9),
		.in_pay    (dpay_s9),
		.out_valid (dv_valid),
		.quo       (quo),
		.out_pay   (dv_pay)
	);
	assign dv_out = ppc_pkg::div_pay_t'(dv_pay);

	// s10: tangent factor a in q1.16
	logic           v_s10;
	logic [16:0]    a_s10;
	ppc_pkg::side_t side_s10;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s10 <= 1'b0;
		else
			v_s10 <= dv_valid;
	end
	always_ff @(posedge clk) begin
		a_s10    <= dv_out.kill ? 17'd0 : ppc_pkg::A_ONE - 17'(quo);
		side_s10 <= dv_out.side;
	end

	// s11: tangent products and reflected normal part
	logic [29:0]        nmx, nmy;
	logic [29:0]        nrx, nry;
	logic signed [17:0] asg;
	logic               v_s11;
	logic signed [47:0] ptx_s11, pty_s11;
	logic signed [29:0] nnx_s11, nny_s11;
	ppc_pkg::side_t     side_s11;
	always_comb begin
		nmx = side_s10.vnx[29] ? $unsigned(-side_s10.vnx) : $unsigned(side_s10.vnx);
		nmy = side_s10.vny[29] ? $unsigned(-side_s10.vny) : $unsigned(side_s10.vny);
		nrx = (nmx + 30'd2) >> 2;
		nry = (nmy + 30'd2) >> 2;
		asg = $signed({1'b0, a_s10});
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s11 <= 1'b0;
		else
			v_s11 <= v_s10;
	end
	always_ff @(posedge clk) begin
		ptx_s11  <= 48'(side_s10.vtx) * 48'(asg);
		pty_s11  <= 48'(side_s10.vty) * 48'(asg);
		// sign flips: -vn/4
		nnx_s11  <= side_s10.vnx[29] ? $signed(nrx) : -$signed(nrx);
		nny_s11  <= side_s10.vny[29] ? $signed(nry) : -$signed(nry);
		side_s11 <= side_s10;
	end

	// s12: tangent scaling, floor by shift, wall by reciprocal of five
	logic [46:0]        tmx, tmy;
	logic [47:0]        rfx, rfy, rwx, rwy;
	logic               v_s12;
	logic [29:0]        tfx_s12, tfy_s12;
	logic [63:0]        ycx_s12, ycy_s12;
	logic               tnx_s12, tny_s12;
	logic signed [29:0] nnx_s12, nny_s12;
	ppc_pkg::side_t     side_s12;
	always_comb begin
		tmx = ptx_s11[47] ? 47'($unsigned(-ptx_s11)) : 47'($unsigned(ptx_s11));
		tmy = pty_s11[47] ? 47'($unsigned(-pty_s11)) : 47'($unsigned(pty_s11));
		rfx = 48'(tmx) + 48'd131072;
		rfy = 48'(tmy) + 48'd131072;
		rwx = 48'(tmx) + 48'(ppc_pkg::WALL_HALF);
		rwy = 48'(tmy) + 48'(ppc_pkg::WALL_HALF);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s12 <= 1'b0;
		else
			v_s12 <= v_s11;
	end
	always_ff @(posedge clk) begin
		tfx_s12  <= rfx[47:18];
		tfy_s12  <= rfy[47:18];
		ycx_s12  <= 64'(rwx[47:16]) * 64'(ppc_pkg::RECIP5);
		ycy_s12  <= 64'(rwy[47:16]) * 64'(ppc_pkg::RECIP5);
		tnx_s12  <= ptx_s11[47];
		tny_s12  <= pty_s11[47];
		nnx_s12  <= nnx_s11;
		nny_s12  <= nny_s11;
		side_s12 <= side_s11;
	end

	// s13: new velocity before the slow boost
	logic [29:0]        tqx, tqy;
	logic               v_s13;
	logic signed [32:0] nvx_s13, nvy_s13;
	ppc_pkg::side_t     side_s13;
	always_comb begin
		tqx = side_s12.flr ? tfx_s12 : ycx_s12[63:34];
		tqy = side_s12.flr ? tfy_s12 : ycy_s12[63:34];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s13 <= 1'b0;
		else
			v_s13 <= v_s12;
	end
	always_ff @(posedge clk) begin
		nvx_s13  <= 33'(nnx_s12) +
			(tnx_s12 ? -$signed(33'(tqx)) : $signed(33'(tqx)));
		nvy_s13  <= 33'(nny_s12) +
			(tny_s12 ? -$signed(33'(tqy)) : $signed(33'(tqy)));
		side_s13 <= side_s12;
	end

	// s14: slow boost for the floor rule, saturation, result register
	logic               smx, smy, boost;
	logic [7:0]         abx, aby;
	logic [16:0]        sqs;
	logic signed [33:0] fvx, fvy;
	logic               v_s14;
	always_comb begin
		smx   = (nvx_s13 > -33'sd205) && (nvx_s13 < 33'sd205);
		smy   = (nvy_s13 > -33'sd205) && (nvy_s13 < 33'sd205);
		abx   = nvx_s13[32] ? 8'($unsigned(-nvx_s13)) : 8'($unsigned(nvx_s13));
		aby   = nvy_s13[32] ? 8'($unsigned(-nvy_s13)) : 8'($unsigned(nvy_s13));
		sqs   = 17'(abx) * 17'(abx) + 17'(aby) * 17'(aby);
		boost = side_s13.flr && smx && smy && (sqs <= ppc_pkg::SLOW_MAX);
		fvx   = boost ? (34'(nvx_s13) <<< 2) : 34'(nvx_s13);
		fvy   = boost ? (34'(nvy_s13) <<< 2) : 34'(nvy_s13);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s14 <= 1'b0;
		else
			v_s14 <= v_s13;
	end
	always_ff @(posedge clk) begin
		new_pos_x  <= side_s13.pnx;
		new_pos_y  <= side_s13.pny;
		new_vel_x  <= side_s13.bnc ? ppc_pkg::sat24(fvx) : side_s13.vx;
		new_vel_y  <= side_s13.bnc ? ppc_pkg::sat24(fvy) : side_s13.vy;
		penetrated <= side_s13.pen;
		bounced    <= side_s13.bnc;
	end
	assign done = v_s14;

	`PPC_ASSERT_IMPLY(a_bounce_needs_pen, clk, arst_n, done, !bounced || penetrated)
	`PPC_ASSERT_IMPLY(a_latency, clk, arst_n, done, $past(accept, LAT))
	`PPC_ASSERT_NEXT(a_kill_zero_a, clk, arst_n, dv_valid && dv_out.kill, a_s10 == 17'd0)

endmodule
